/* hw/rtl/lpfr_pkg.sv */
`default_nettype none
package lpfr_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  // 0x8005 bit-reversed, for the right-shifting register
  localparam logic [15:0] CRC_POLY_REFLECTED = 16'hA001;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam logic [LEN_W-1:0] MIN_BODY_LEN = 16'd3;

  typedef enum logic [1:0] {
    PH_LEN_HI = 2'd0,
    PH_LEN_LO = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    KIND_CMD     = 3'd0,
    KIND_DATA    = 3'd1,
    KIND_GOOD    = 3'd2,
    KIND_CRCFAIL = 3'd3,
    KIND_SHORT   = 3'd4
  } kind_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [BYTE_W-1:0] value;
    logic              frame_end;
  } result_t;

endpackage
`default_nettype wire

/* hw/rtl/lpfr_crc16.sv */
`default_nettype none
module lpfr_crc16 (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data,
  output logic      [15:0] crc_out
);

  // eight shift steps of the reflected register, one per data bit
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ lpfr_pkg::CRC_POLY_REFLECTED;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule
`default_nettype wire

/* hw/rtl/lpfr_parser.sv */
`default_nettype none
module lpfr_parser (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            step,
  input  wire logic [lpfr_pkg::BYTE_W-1:0]     data,
  output lpfr_pkg::result_t                    result
);

  lpfr_pkg::phase_t            phase;
  lpfr_pkg::phase_t            phase_next;
  logic [lpfr_pkg::LEN_W-1:0]  body_length;
  logic [lpfr_pkg::LEN_W-1:0]  body_length_next;
  logic [lpfr_pkg::LEN_W-1:0]  body_count;
  logic [lpfr_pkg::LEN_W-1:0]  body_count_next;
  logic [15:0]                 crc_register;
  logic [15:0]                 crc_register_next;
  logic [15:0]                 crc_upd;
  logic [lpfr_pkg::LEN_W-1:0]  len_lo;
  logic                        len_short;
  logic                        last_byte;
  logic                        data_byte;

  lpfr_crc16 u_crc (
    .crc_in  (crc_register),
    .data    (data),
    .crc_out (crc_upd)
  );

  assign len_lo    = {body_length[15:8], data};
  assign len_short = len_lo < lpfr_pkg::MIN_BODY_LEN;
  // idx + 1 >= L and idx + 2 < L, carried in 17 bits
  assign last_byte = ({1'b0, body_count} + 17'd1) >= {1'b0, body_length};
  assign data_byte = ({1'b0, body_count} + 17'd2) < {1'b0, body_length};

  // next phase
  always_comb begin
    unique case (phase)
      lpfr_pkg::PH_LEN_LO: phase_next = len_short ? lpfr_pkg::PH_LEN_HI : lpfr_pkg::PH_BODY;
      lpfr_pkg::PH_BODY:   phase_next = last_byte ? lpfr_pkg::PH_LEN_HI : lpfr_pkg::PH_BODY;
      default:             phase_next = lpfr_pkg::PH_LEN_LO;
    endcase
  end

  // datapath next values
  always_comb begin
    body_length_next  = body_length;
    body_count_next   = body_count;
    crc_register_next = crc_register;
    unique case (phase)
      lpfr_pkg::PH_LEN_LO: begin
        body_length_next  = len_lo;
        body_count_next   = '0;
        crc_register_next = lpfr_pkg::CRC_INIT;
      end
      lpfr_pkg::PH_BODY: begin
        body_count_next   = body_count + 16'd1;
        crc_register_next = crc_upd;
      end
      default: begin
        body_length_next = {data, 8'h00};
      end
    endcase
  end

  // result for the byte now in hand
  always_comb begin
    result = '{valid: 1'b0, kind: lpfr_pkg::KIND_CMD, value: '0, frame_end: 1'b0};
    unique case (phase)
      lpfr_pkg::PH_LEN_LO: begin
        if (len_short) begin
          result = '{valid: 1'b1, kind: lpfr_pkg::KIND_SHORT, value: '0, frame_end: 1'b1};
        end
      end
      lpfr_pkg::PH_BODY: begin
        priority if (last_byte) begin
          result.valid     = 1'b1;
          result.kind      = (crc_upd == 16'h0000) ? lpfr_pkg::KIND_GOOD
                                                   : lpfr_pkg::KIND_CRCFAIL;
          result.frame_end = 1'b1;
        end else if (body_count == '0) begin
          result = '{valid: 1'b1, kind: lpfr_pkg::KIND_CMD, value: data, frame_end: 1'b0};
        end else if (data_byte) begin
          result = '{valid: 1'b1, kind: lpfr_pkg::KIND_DATA, value: data, frame_end: 1'b0};
        end else begin
          result.valid = 1'b0;
        end
      end
      default: begin
        result.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= lpfr_pkg::PH_LEN_HI;
      body_length  <= '0;
      body_count   <= '0;
      crc_register <= lpfr_pkg::CRC_INIT;
    end else if (step) begin
      phase        <= phase_next;
      body_length  <= body_length_next;
      body_count   <= body_count_next;
      crc_register <= crc_register_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/length_prefixed_frame_receiver_crc16.sv */
`default_nettype none
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+--------------------------
// input    | in_valid  | in_stall  | rx_byte
// output   | out_valid | out_stall | kind, value, frame_end
//
// one byte per cycle sustained while out_stall is low; a byte passes through the
// input register, and its result is then loaded into the result register
// the rate is set by the byte-wide crc-16 update and phase logic, which close
// the state loop combinationally
// rst is synchronous: clears the input and result valids, the phase and the crc
// out_stall holds a full result register and, while it holds, the input register
// in_stall rises only when the input register is full and cannot move on
module length_prefixed_frame_receiver_crc16 (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      kind,
  output logic [7:0]      value,
  output logic            frame_end
);

  // input register
  logic       in_full;
  logic [7:0] in_byte;

  // the stage moves when the result register is empty or being drained
  logic advance;
  logic step;

  lpfr_pkg::result_t result;

  assign advance  = !out_valid || !out_stall;
  assign step     = in_full && advance;
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte <= rx_byte;
    end
  end

  // frame parser: phase, length, count and running crc
  lpfr_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .data   (in_byte),
    .result (result)
  );

  // result register; bytes that give no result just leave it empty
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step && result.valid) begin
      kind      <= result.kind;
      value     <= result.value;
      frame_end <= result.frame_end;
    end
  end

endmodule
`default_nettype wire
